>>> hw/rtl/aled_pkg.sv
// Shared types, codes and the brightness scaling function for the LED frame driver.
// No dependencies; imported by every module of the block.
package aled_pkg;

  parameter int unsigned DEF_MAX_LED_COUNT = 64;
  parameter int unsigned BITS_PER_LED      = 24;

  // Command codes
  localparam logic [2:0] CMD_SET       = 3'd0;
  localparam logic [2:0] CMD_SET_LEVEL = 3'd1;
  localparam logic [2:0] CMD_READ      = 3'd2;
  localparam logic [2:0] CMD_START     = 3'd3;
  localparam logic [2:0] CMD_TICK      = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  // Brightness levels
  localparam logic [2:0] LVL_OFF     = 3'd0;
  localparam logic [2:0] LVL_THIRD   = 3'd1;
  localparam logic [2:0] LVL_HALF    = 3'd2;
  localparam logic [2:0] LVL_3QUART  = 3'd3;
  localparam logic [2:0] LVL_FULL_LO = 3'd4;
  localparam logic [2:0] LVL_FULL_HI = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [2:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [2:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [2:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [2:0] CFG_LATCH_LOW = 3'd4;

  localparam logic [9:0]  RST_ZERO_HIGH = 10'd19;
  localparam logic [9:0]  RST_ZERO_LOW  = 10'd41;
  localparam logic [9:0]  RST_ONE_HIGH  = 10'd38;
  localparam logic [9:0]  RST_ONE_LOW   = 10'd22;
  localparam logic [15:0] RST_LATCH_LOW = 16'd2400;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] led_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [2:0] level_in;
  } aled_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [2:0] level_out;
    logic [6:0] led_count;
    logic       sending;
    logic       data_line;
  } aled_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture request, read store
    logic commit;  // execute request, load result register
  } aled_ctl_t;

  // Scale one colour component by a brightness level.
  // Divide by 3 is a multiply by 171 and a shift by 9, exact for 8-bit values.
  function automatic logic [7:0] scale_level(logic [7:0] c, logic [2:0] lv);
    logic [16:0] prod;
    logic [5:0]  quart;
    logic [7:0]  res;
    prod  = 17'(c) * 17'd171;
    quart = c[7:2];
    case (lv) inside
      LVL_OFF:                   res = 8'd0;
      LVL_THIRD:                 res = prod[16:9];
      LVL_HALF:                  res = {1'b0, c[7:1]};
      LVL_3QUART:                res = 8'(quart) + {1'b0, quart, 1'b0};
      [LVL_FULL_LO:LVL_FULL_HI]: res = c;
      default:                   res = c;
    endcase
    return res;
  endfunction

endpackage

>>> hw/rtl/addressable_led_frame_driver.sv
// Top level of the addressable LED frame driver: request sequencer plus datapath.
// Depends on aled_pkg, aled_ctrl and aled_dp.
//
//   port group   direction  handshake            payload
//   in_*         in         in_valid_i/in_stall_o  aled_in_t  (command request)
//   out_*        out        out_valid_o/out_stall_i aled_out_t (one result per request)
//   cfg_*        in         cfg_valid_i/cfg_ready_o index 3b, data 16b (always ready)
//
// Each request is captured, and the frame store read through its registered read port,
// on acceptance; the request is then executed and the result register loaded.
// A request waits in execute while the previous result is stalled at the output.
// Reset clears the frame store valid bits, so the whole store reads as zero at once.
// Timing registers come out of reset at 19/41/38/22/2400 ticks.
module addressable_led_frame_driver import aled_pkg::*; #(
  parameter int unsigned MAX_LED_COUNT = DEF_MAX_LED_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  aled_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output aled_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  aled_ctl_t ctl;

  assign cfg_ready_o = 1'b1;

  aled_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  aled_dp #(
    .MAX_LED_COUNT (MAX_LED_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/aled_ctrl.sv
// Request sequencer of the LED frame driver: accept, execute, hand over the result.
// Depends on aled_pkg for the command struct.
module aled_ctrl import aled_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output aled_ctl_t ctl_o
);

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    ctl_o.load   = (state_q == S_IDLE) && in_valid_i;
    ctl_o.commit = (state_q == S_EXEC) && slot_free;
    state_d      = state_q;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        // hold here while the previous result is still not taken
        if (slot_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> in_stall_o)
    else $error("accepted request did not block the input");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |=> out_valid_o)
    else $error("committed request produced no result");

  a_wait_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_valid_q && out_stall_i) |=> (state_q == S_EXEC))
    else $error("request left execute while result slot was full");

  a_no_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !ctl_o.commit)
    else $error("commit without a pending request");

endmodule

>>> hw/rtl/aled_dp.sv
// Datapath of the LED frame driver: frame store, timing registers, line waveform
// sequencer and result register. Depends on aled_pkg.
module aled_dp import aled_pkg::*; #(
  parameter int unsigned MAX_LED_COUNT = DEF_MAX_LED_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  aled_ctl_t  ctl_i,
  input  aled_in_t   in_data_i,
  input  logic       cfg_valid_i,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output aled_out_t  out_data_o
);

  localparam int unsigned PTR_W = (MAX_LED_COUNT > 1) ? $clog2(MAX_LED_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LED_COUNT + 1);
  localparam int unsigned NXT_W = CNT_W + 1;
  localparam logic [4:0]  LAST_BIT = 5'(BITS_PER_LED - 1);

  typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW, PH_LATCH} phase_e;

  // Frame store
  logic [23:0] colour_mem [MAX_LED_COUNT];
  logic [2:0]  level_mem  [MAX_LED_COUNT];
  logic [MAX_LED_COUNT-1:0] colour_vld_q, level_vld_q;

  logic [PTR_W-1:0] rd_addr, wr_addr;
  logic [23:0] rd_colour_q, wr_colour;
  logic [2:0]  rd_level_q;
  logic        rd_cvld_q, rd_lvld_q;
  logic        we_colour, we_level;

  // Control state
  phase_e           phase_q, phase_d;
  logic             line_q, line_d;
  logic [PTR_W-1:0] led_ptr_q, led_ptr_d;
  logic [4:0]       bit_ptr_q, bit_ptr_d;
  logic [15:0]      tick_cnt_q, tick_cnt_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [9:0]  zero_high_q, zero_low_q, one_high_q, one_low_q;
  logic [15:0] latch_low_q;

  aled_in_t  req_q;
  aled_out_t out_q, out_d;

  logic        busy, in_range, cur_bit;
  logic [23:0] cur_word;
  logic [16:0] cnt_inc, limit;
  logic [NXT_W-1:0] led_next;

  // Read the addressed entry for a read, else the LED being sent
  assign rd_addr = (in_data_i.cmd == CMD_READ) ? in_data_i.led_index[PTR_W-1:0] : led_ptr_q;
  assign wr_addr = req_q.led_index[PTR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rd_colour_q <= colour_mem[rd_addr];
      rd_level_q  <= level_mem[rd_addr];
      rd_cvld_q   <= colour_vld_q[rd_addr];
      rd_lvld_q   <= level_vld_q[rd_addr];
    end
    if (we_colour) colour_mem[wr_addr] <= wr_colour;
    if (we_level)  level_mem[wr_addr]  <= req_q.level_in;
  end

  assign busy     = (phase_q != PH_IDLE);
  assign in_range = (req_q.led_index < 8'(MAX_LED_COUNT));
  assign cur_word = rd_cvld_q ? rd_colour_q : 24'd0;
  assign cur_bit  = cur_word[LAST_BIT - bit_ptr_q];
  assign cnt_inc  = {1'b0, tick_cnt_q} + 17'd1;
  assign led_next = NXT_W'(led_ptr_q) + NXT_W'(1);

  always_comb begin
    if (req_q.cmd == CMD_SET_LEVEL) begin
      wr_colour = {scale_level(req_q.green_in, req_q.level_in),
                   scale_level(req_q.red_in,   req_q.level_in),
                   scale_level(req_q.blue_in,  req_q.level_in)};
    end else begin
      wr_colour = {req_q.green_in, req_q.red_in, req_q.blue_in};
    end
  end

  always_comb begin
    phase_d    = phase_q;
    line_d     = line_q;
    led_ptr_d  = led_ptr_q;
    bit_ptr_d  = bit_ptr_q;
    tick_cnt_d = tick_cnt_q;
    count_d    = count_q;
    we_colour  = 1'b0;
    we_level   = 1'b0;
    limit      = 17'd0;
    out_d      = '0;
    out_d.status = ST_OK;
    if (ctl_i.commit) begin
      case (req_q.cmd)
        CMD_SET, CMD_SET_LEVEL: begin
          if (!in_range) begin
            out_d.status = ST_RANGE;
          end else if (busy) begin
            out_d.status = ST_BUSY;
          end else begin
            we_colour = 1'b1;
            we_level  = (req_q.cmd == CMD_SET_LEVEL);
            if (req_q.led_index >= 8'(count_q)) begin
              count_d = CNT_W'({1'b0, req_q.led_index} + 9'd1);
            end
          end
        end
        CMD_READ: begin
          if (!in_range) begin
            out_d.status = ST_RANGE;
          end else begin
            out_d.green_out = cur_word[23:16];
            out_d.red_out   = cur_word[15:8];
            out_d.blue_out  = cur_word[7:0];
            out_d.level_out = rd_lvld_q ? rd_level_q : 3'd0;
          end
        end
        CMD_START: begin
          if (busy) begin
            out_d.status = ST_BUSY;
          end else begin
            led_ptr_d  = '0;
            bit_ptr_d  = '0;
            tick_cnt_d = '0;
            if (count_q == '0) begin
              phase_d = PH_LATCH;
              line_d  = 1'b0;
            end else begin
              phase_d = PH_HIGH;
              line_d  = 1'b1;
            end
          end
        end
        CMD_TICK: begin
          tick_cnt_d = cnt_inc[15:0];
          case (phase_q)
            PH_HIGH: begin
              limit = cur_bit ? 17'(one_high_q) : 17'(zero_high_q);
              if (cnt_inc >= limit) begin
                phase_d    = PH_LOW;
                line_d     = 1'b0;
                tick_cnt_d = '0;
              end
            end
            PH_LOW: begin
              limit = cur_bit ? 17'(one_low_q) : 17'(zero_low_q);
              if (cnt_inc >= limit) begin
                tick_cnt_d = '0;
                if (bit_ptr_q < LAST_BIT) begin
                  bit_ptr_d = bit_ptr_q + 5'd1;
                  phase_d   = PH_HIGH;
                  line_d    = 1'b1;
                end else begin
                  bit_ptr_d = '0;
                  if (led_next < NXT_W'(count_q)) begin
                    led_ptr_d = led_next[PTR_W-1:0];
                    phase_d   = PH_HIGH;
                    line_d    = 1'b1;
                  end else begin
                    // last LED done: go to the latch period
                    led_ptr_d = '0;
                    phase_d   = PH_LATCH;
                    line_d    = 1'b0;
                  end
                end
              end
            end
            PH_LATCH: begin
              limit = 17'(latch_low_q);
              if (cnt_inc >= limit) begin
                phase_d    = PH_IDLE;
                tick_cnt_d = '0;
              end
            end
            default: tick_cnt_d = tick_cnt_q;  // idle: ticks change nothing
          endcase
        end
        default: ;
      endcase
    end
    out_d.led_count = 7'(count_d);
    out_d.sending   = (phase_d != PH_IDLE);
    out_d.data_line = line_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      line_q       <= 1'b0;
      led_ptr_q    <= '0;
      bit_ptr_q    <= '0;
      tick_cnt_q   <= '0;
      count_q      <= '0;
      colour_vld_q <= '0;
      level_vld_q  <= '0;
      zero_high_q  <= RST_ZERO_HIGH;
      zero_low_q   <= RST_ZERO_LOW;
      one_high_q   <= RST_ONE_HIGH;
      one_low_q    <= RST_ONE_LOW;
      latch_low_q  <= RST_LATCH_LOW;
    end else begin
      phase_q    <= phase_d;
      line_q     <= line_d;
      led_ptr_q  <= led_ptr_d;
      bit_ptr_q  <= bit_ptr_d;
      tick_cnt_q <= tick_cnt_d;
      count_q    <= count_d;
      if (we_colour) colour_vld_q[wr_addr] <= 1'b1;
      if (we_level)  level_vld_q[wr_addr]  <= 1'b1;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ZERO_HIGH: zero_high_q <= cfg_data_i[9:0];
          CFG_ZERO_LOW:  zero_low_q  <= cfg_data_i[9:0];
          CFG_ONE_HIGH:  one_high_q  <= cfg_data_i[9:0];
          CFG_ONE_LOW:   one_low_q   <= cfg_data_i[9:0];
          CFG_LATCH_LOW: latch_low_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load)   req_q <= in_data_i;
    if (ctl_i.commit) out_q <= out_d;
  end

  assign out_data_o = out_q;

  a_ptr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HIGH || phase_q == PH_LOW) |-> (NXT_W'(led_ptr_q) < NXT_W'(count_q)))
    else $error("LED pointer beyond frame while sending");

  a_line_high_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q |-> (phase_q == PH_HIGH))
    else $error("data line high outside a high pulse");

  a_bit_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_ptr_q <= LAST_BIT)
    else $error("bit pointer beyond last colour bit");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the addressable LED frame driver.
// Uses aled_pkg types and codes; predicts results with its own frame and line model, or takes them from a typed row.
module testbench;
  import aled_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = DEF_MAX_LED_COUNT;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {LINE_IDLE, LINE_HIGH, LINE_LOW, LINE_LATCH} line_phase_e;

  typedef struct {
    aled_in_t  req;
    bit        drain;
    bit        typed;
    aled_out_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  aled_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  aled_out_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  addressable_led_frame_driver u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Frame store and line state as the block should hold them
  logic [23:0]  frame_rgb [STORE_DEPTH];
  logic [2:0]   frame_lvl [STORE_DEPTH];
  logic [6:0]   lit_count = '0;
  logic         tx_busy = 1'b0;
  int           tx_led = 0;
  int           tx_bit = 0;
  line_phase_e  tx_phase = LINE_IDLE;
  int unsigned  tx_ticks = 0;
  logic         tx_line = 1'b0;
  logic [9:0]   t_zero_hi = RST_ZERO_HIGH;
  logic [9:0]   t_zero_lo = RST_ZERO_LOW;
  logic [9:0]   t_one_hi = RST_ONE_HIGH;
  logic [9:0]   t_one_lo = RST_ONE_LOW;
  logic [15:0]  t_latch = RST_LATCH_LOW;

  aled_out_t    pending_results [$];
  dir_row_t     dir_rows [$];
  aled_out_t    rx_want;
  int           rx_hold = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           calm = 1'b0;

  initial begin
    foreach (frame_rgb[i]) begin
      frame_rgb[i] = '0;
      frame_lvl[i] = '0;
    end
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] dim(logic [7:0] c, logic [2:0] lv);
    case (lv)
      LVL_OFF:    return 8'd0;
      LVL_THIRD:  return c / 8'd3;
      LVL_HALF:   return c >> 1;
      LVL_3QUART: return (c >> 2) * 8'd3;
      default:    return c;
    endcase
  endfunction

  function automatic void start_bit();
    tx_phase = LINE_HIGH;
    tx_line  = 1'b1;
    tx_ticks = 0;
  endfunction

  // One timer tick of the line waveform
  function automatic void advance_line();
    logic one;
    if (tx_phase == LINE_IDLE) return;
    tx_ticks++;
    one = frame_rgb[tx_led][23 - tx_bit];
    case (tx_phase)
      LINE_HIGH: begin
        if (tx_ticks >= (one ? t_one_hi : t_zero_hi)) begin
          tx_phase = LINE_LOW;
          tx_line  = 1'b0;
          tx_ticks = 0;
        end
      end
      LINE_LOW: begin
        if (tx_ticks >= (one ? t_one_lo : t_zero_lo)) begin
          tx_ticks = 0;
          if (tx_bit < 23) begin
            tx_bit++;
            start_bit();
          end else begin
            tx_bit = 0;
            tx_led++;
            if (tx_led < lit_count) begin
              start_bit();
            end else begin
              tx_led   = 0;
              tx_phase = LINE_LATCH;
              tx_line  = 1'b0;
            end
          end
        end
      end
      default: begin
        if (tx_ticks >= t_latch) begin
          tx_phase = LINE_IDLE;
          tx_busy  = 1'b0;
          tx_ticks = 0;
        end
      end
    endcase
  endfunction

  function automatic aled_out_t next_led_result(aled_in_t req);
    aled_out_t  res;
    logic [7:0] r, g, b;
    logic [5:0] idx;
    res = '0;
    r   = req.red_in;
    g   = req.green_in;
    b   = req.blue_in;
    idx = req.led_index[5:0];
    case (req.cmd)
      CMD_SET, CMD_SET_LEVEL: begin
        if (req.led_index >= STORE_DEPTH) begin
          res.status = ST_RANGE;
        end else if (tx_busy) begin
          res.status = ST_BUSY;
        end else begin
          if (req.cmd == CMD_SET_LEVEL) begin
            frame_lvl[idx] = req.level_in;
            r = dim(r, req.level_in);
            g = dim(g, req.level_in);
            b = dim(b, req.level_in);
          end
          frame_rgb[idx] = {g, r, b};
          if (req.led_index >= lit_count) lit_count = 7'(req.led_index + 1);
        end
      end
      CMD_READ: begin
        if (req.led_index >= STORE_DEPTH) begin
          res.status = ST_RANGE;
        end else begin
          {res.green_out, res.red_out, res.blue_out} = frame_rgb[idx];
          res.level_out = frame_lvl[idx];
        end
      end
      CMD_START: begin
        if (tx_busy) begin
          res.status = ST_BUSY;
        end else begin
          tx_busy  = 1'b1;
          tx_led   = 0;
          tx_bit   = 0;
          tx_ticks = 0;
          if (lit_count == 0) begin
            tx_phase = LINE_LATCH;
            tx_line  = 1'b0;
          end else begin
            start_bit();
          end
        end
      end
      CMD_TICK: advance_line();
      default: ;
    endcase
    res.led_count = lit_count;
    res.sending   = tx_busy;
    res.data_line = tx_line;
    return res;
  endfunction

  function automatic aled_in_t led_req(logic [2:0] cmd, logic [7:0] idx, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b, logic [2:0] lv);
    return '{cmd, idx, r, g, b, lv};
  endfunction

  function automatic aled_out_t led_res(logic [1:0] st, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b, logic [2:0] lv, logic [6:0] cnt,
                                        logic snd, logic ln);
    return '{st, r, g, b, lv, cnt, snd, ln};
  endfunction

  function automatic void add_row(aled_in_t req, bit drain, bit typed = 1'b0,
                                  aled_out_t want = '0);
    dir_rows.push_back(dir_row_t'{req, drain, typed, want});
  endfunction

  function automatic aled_in_t random_fields(logic [2:0] cmd);
    return led_req(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)));
  endfunction

  // Writes land mostly on 0..wr_top so the frame length stays under control
  function automatic aled_in_t random_request(int wr_top);
    aled_in_t req;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      req = random_fields(pick < 15 ? CMD_SET : CMD_SET_LEVEL);
      req.led_index = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(STORE_DEPTH, 255))
                                                   : 8'($urandom_range(0, wr_top));
    end else if (pick < 55) begin
      req = random_fields(CMD_READ);
      if ($urandom_range(0, 5) != 0) req.led_index = 8'($urandom_range(0, STORE_DEPTH - 1));
    end else if (pick < 63) begin
      req = random_fields(CMD_START);
    end else if (pick < 70) begin
      req = random_fields(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
    end else begin
      req = random_fields(CMD_TICK);
    end
    return req;
  endfunction

  task automatic report_mismatch(string what, aled_out_t got, aled_out_t want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  task automatic send_request(aled_in_t req, bit typed = 1'b0, aled_out_t want = '0);
    int        gap;
    aled_out_t guess;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    guess = next_led_result(req);
    pending_results.push_back(typed ? want : guess);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ZERO_HIGH: t_zero_hi = data[9:0];
      CFG_ZERO_LOW:  t_zero_lo = data[9:0];
      CFG_ONE_HIGH:  t_one_hi = data[9:0];
      CFG_ONE_LOW:   t_one_lo = data[9:0];
      CFG_LATCH_LOW: t_latch = data;
      default: ;
    endcase
  endtask

  task automatic set_timing(logic [15:0] zh, logic [15:0] zl, logic [15:0] oh,
                            logic [15:0] ol, logic [15:0] lat);
    settle();
    write_cfg(CFG_ZERO_HIGH, zh);
    write_cfg(CFG_ZERO_LOW, zl);
    write_cfg(CFG_ONE_HIGH, oh);
    write_cfg(CFG_ONE_LOW, ol);
    write_cfg(CFG_LATCH_LOW, lat);
    cfg_valid_i <= 1'b0;
  endtask

  // Tick until the frame and its latch period are done, with other requests mixed in
  task automatic finish_frame(int wr_top);
    while (tx_busy)
      send_request(($urandom_range(0, 4) == 0) ? random_request(wr_top)
                                                : random_fields(CMD_TICK));
  endtask

  // Tick part of a frame at the current timings, then shorten what is left of it
  task automatic cut_frame(int ticks);
    repeat (ticks) send_request(random_fields(CMD_TICK));
    if (tx_phase == LINE_LATCH) begin
      // keep the bit timings as they are, only end the latch period
      settle();
      write_cfg(CFG_LATCH_LOW, 16'd1);
      cfg_valid_i <= 1'b0;
    end else begin
      set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    end
    finish_frame(1);
  endtask

  task automatic run_rounds(int rounds, int wr_top);
    for (int r = 0; r < rounds; r++) begin
      repeat ($urandom_range(1, 8)) send_request(random_request(wr_top));
      send_request(random_fields(CMD_START));
      finish_frame(wr_top);
      if ($urandom_range(0, 2) == 0) calm = !calm;
    end
  endtask

  // Random requests over the whole store, no frame started
  task automatic fill_store(int n);
    aled_in_t req;
    repeat (n) begin
      req = random_request(STORE_DEPTH - 1);
      if (req.cmd == CMD_START) req.cmd = CMD_READ;
      send_request(req);
    end
  endtask

  // Result side: check, then hold stall for a random spell, none when calm
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", out_data_o, '0);
        end else begin
          rx_want = pending_results.pop_front();
          if (out_data_o.status !== rx_want.status)
            report_mismatch("status", out_data_o, rx_want);
          if (out_data_o.red_out !== rx_want.red_out)
            report_mismatch("red_out", out_data_o, rx_want);
          if (out_data_o.green_out !== rx_want.green_out)
            report_mismatch("green_out", out_data_o, rx_want);
          if (out_data_o.blue_out !== rx_want.blue_out)
            report_mismatch("blue_out", out_data_o, rx_want);
          if (out_data_o.level_out !== rx_want.level_out)
            report_mismatch("level_out", out_data_o, rx_want);
          if (out_data_o.led_count !== rx_want.led_count)
            report_mismatch("led_count", out_data_o, rx_want);
          if (out_data_o.sending !== rx_want.sending)
            report_mismatch("sending", out_data_o, rx_want);
          if (out_data_o.data_line !== rx_want.data_line)
            report_mismatch("data_line", out_data_o, rx_want);
        end
        rx_hold = calm ? 0 : $urandom_range(0, 14);
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      out_stall_i <= (rx_hold != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // Reset state, error codes and a start with an empty frame
    add_row(led_req(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_OK, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b0, 1'b0));
    add_row(led_req(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, LVL_FULL_HI), 1'b0, 1'b1,
            led_res(ST_RANGE, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b0, 1'b0));
    add_row(led_req(CMD_TICK, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_OK, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b0, 1'b0));
    add_row(led_req(CMD_UNUSED_LO, 8'd3, 8'h12, 8'h34, 8'h56, LVL_HALF), 1'b0, 1'b1,
            led_res(ST_OK, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b0, 1'b0));
    add_row(led_req(CMD_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, LVL_FULL_HI), 1'b0, 1'b1,
            led_res(ST_OK, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b0, 1'b0));
    add_row(led_req(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_OK, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b1, 1'b0));
    add_row(led_req(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_BUSY, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b1, 1'b0));
    add_row(led_req(CMD_SET, 8'd5, 8'hFF, 8'hFF, 8'hFF, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_BUSY, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b1, 1'b0));
    add_row(led_req(CMD_SET, 8'd64, 8'hFF, 8'hFF, 8'hFF, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_RANGE, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b1, 1'b0));
    add_row(led_req(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b1, 1'b1,
            led_res(ST_OK, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd0, 1'b1, 1'b0));
    // Colour writes, every brightness level, level kept by a plain write
    add_row(led_req(CMD_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_OK, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd1, 1'b0, 1'b0));
    add_row(led_req(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_OK, 8'hFF, 8'hFF, 8'hFF, LVL_OFF, 7'd1, 1'b0, 1'b0));
    add_row(led_req(CMD_SET_LEVEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_OK, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd1, 1'b0, 1'b0));
    add_row(led_req(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0, 1'b1,
            led_res(ST_OK, 8'h00, 8'h00, 8'h00, LVL_OFF, 7'd1, 1'b0, 1'b0));
    add_row(led_req(CMD_SET_LEVEL, 8'd0, 8'hFF, 8'h80, 8'h01, LVL_THIRD), 1'b0);
    add_row(led_req(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0);
    add_row(led_req(CMD_SET_LEVEL, 8'd0, 8'hFE, 8'h7F, 8'h03, LVL_HALF), 1'b0);
    add_row(led_req(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0);
    add_row(led_req(CMD_SET_LEVEL, 8'd0, 8'hFF, 8'h0F, 8'h04, LVL_3QUART), 1'b0);
    add_row(led_req(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0);
    add_row(led_req(CMD_SET_LEVEL, 8'd0, 8'hA5, 8'h5A, 8'hC3, LVL_FULL_LO), 1'b0);
    add_row(led_req(CMD_SET_LEVEL, 8'd0, 8'h12, 8'h34, 8'h56, LVL_FULL_HI), 1'b0);
    add_row(led_req(CMD_SET, 8'd0, 8'hEE, 8'h5D, 8'hCC, LVL_OFF), 1'b0);
    add_row(led_req(CMD_READ, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b0);
    // Frame at the reset bit timings: green starts with a zero bit, then a one bit
    add_row(led_req(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF), 1'b1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      // a latch period only needs a taste; a frame gets its first two bits in full
      if (dir_rows[i].drain) cut_frame((tx_phase == LINE_LATCH) ? 20 : 125);
    end

    // Long zero-bit pulses: one zero bit in an otherwise all-ones frame
    set_timing(16'h040C, 16'd9, 16'd1, 16'd1, 16'd1);
    send_request(led_req(CMD_SET, 8'd0, 8'hFF, 8'hFF, 8'hFE, LVL_OFF));
    send_request(led_req(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF));
    finish_frame(1);

    // Long one-bit pulses: one one bit in an otherwise all-zeros frame
    set_timing(16'd1, 16'd1, 16'd11, 16'hFC07, 16'd1);
    send_request(led_req(CMD_SET, 8'd0, 8'h00, 8'h00, 8'h01, LVL_OFF));
    send_request(led_req(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF));
    finish_frame(1);

    // Zero timings act as one tick, latch period too; run without idling
    calm = 1'b1;
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(random_fields(CMD_SET));
    send_request(led_req(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00, LVL_OFF));
    finish_frame(1);
    calm = 1'b0;

    set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    run_rounds(1, 0);

    repeat (2) begin
      set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                 16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                 16'($urandom_range(0, 15)));
      run_rounds(1, 0);
    end

    // Whole store in use
    send_request(led_req(CMD_SET_LEVEL, 8'd63, 8'hFF, 8'hFF, 8'hFF, LVL_FULL_HI));
    fill_store(20);

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
